[rtl/core/svvs_pkg.sv]
// Shared types, constants and arithmetic helpers for the sphere velocity-Verlet pipeline.
// Used by svvs_front, svvs_ph1, svvs_ph2 and the top level; depends on nothing.
`timescale 1ns / 1ps
package svvs_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int PH1_STEPS = PROD_W + 1;
    localparam int PH2_STEPS = PROD_W;

    localparam logic [WORD_W-1:0] POS_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] NEG_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic [1:0] REG_ENABLE          = 2'd0;
    localparam logic [1:0] REG_STEP_TIME       = 2'd1;
    localparam logic [1:0] REG_HALF_STEP_FORCE = 2'd2;

    localparam logic [3:0] FIVE = 4'd5;

    typedef struct packed {
        logic              enable;
        logic [WORD_W-1:0] step_time;
        logic [WORD_W-1:0] half_step_force;
    } cfg_t;

    typedef struct packed {
        logic              cmd;
        logic              grp;
        logic              last;
        logic [WORD_W-1:0] mass;
        logic [WORD_W-1:0] radius;
        logic [WORD_W-1:0] force_req;
        logic [WORD_W-1:0] torque;
        logic [WORD_W-1:0] vel;
        logic [WORD_W-1:0] pos;
        logic [WORD_W-1:0] spin;
    } in_t;

    // Fields that ride along the whole pipe
    typedef struct packed {
        logic              cmd;
        logic              last;
        logic              act;
        logic              bad;
        logic              nf;
        logic              nt;
        logic [WORD_W-1:0] mass;
        logic [WORD_W-1:0] vel;
        logic [WORD_W-1:0] pos;
        logic [WORD_W-1:0] spin;
    } base_t;

    typedef struct packed {
        base_t             b;
        logic [PROD_W-1:0] pf;
        logic [PROD_W-1:0] pt;
        logic [PROD_W-1:0] q2;
    } front_t;

    typedef struct packed {
        base_t             b;
        logic [PROD_W-1:0] pt;
        logic [PROD_W:0]   vd_dvd;
        logic [WORD_W-1:0] vd_rem;
        logic [PROD_W-1:0] vd_q;
        logic [PROD_W:0]   i_n;
        logic [PROD_W:0]   i_est;
        logic [PROD_W-1:0] i_q;
    } ph1_t;

    typedef struct packed {
        logic [WORD_W-1:0] nv;
        logic [WORD_W-1:0] nx;
        logic [WORD_W-1:0] nw;
        logic              bad;
        logic              sat;
        logic              last;
    } out_t;

    // {negative, magnitude} of a two's complement word
    function automatic logic [WORD_W:0] split(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] mag;
        mag = x[WORD_W-1] ? (~x + 1'b1) : x;
        return {x[WORD_W-1], mag};
    endfunction

    // {clipped, result} of a + (+/-)mb, clamped to the signed word range
    function automatic logic [WORD_W:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic nb,
                                                input logic [PROD_W-1:0] mb,
                                                input logic huge);
        logic signed [PROD_W+1:0] sa;
        logic signed [PROD_W+1:0] sb;
        logic signed [PROD_W+1:0] sum;
        logic [WORD_W:0]          r;
        sa  = (PROD_W+2)'($signed(a));
        sb  = nb ? -$signed({2'b00, mb}) : $signed({2'b00, mb});
        sum = sa + sb;
        if (huge) begin
            r = {1'b1, nb ? NEG_MIN : POS_MAX};
        end else if (sum > $signed({{(PROD_W-WORD_W+2){1'b0}}, POS_MAX})) begin
            r = {1'b1, POS_MAX};
        end else if (sum < -$signed({{(PROD_W-WORD_W+1){1'b0}}, NEG_MIN, 1'b0}) / 2) begin
            r = {1'b1, NEG_MIN};
        end else begin
            r = {1'b0, sum[WORD_W-1:0]};
        end
        return r;
    endfunction

endpackage

[rtl/core/svvs_front.sv]
// Entry stages: sign split, force/torque numerators and moment-of-inertia product.
// Depends on svvs_pkg.
`timescale 1ns / 1ps
module svvs_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  svvs_pkg::cfg_t  cfg,
    input  logic            in_valid,
    input  svvs_pkg::in_t   in_data,
    output logic            out_valid,
    output svvs_pkg::front_t out_data
);
    import svvs_pkg::*;

    logic [WORD_W:0] fs, ts;
    base_t           b_next;

    base_t             b0_reg, b1_reg, b2_reg;
    logic [WORD_W-1:0] mf0_reg, mt0_reg, rad0_reg;
    logic [PROD_W-1:0] pf1_reg, pt1_reg, rr1_reg;
    logic [PROD_W-1:0] pf2_reg, pt2_reg, plo2_reg;
    logic [PROD_W-FRAC_BITS-1:0] phi2_reg;
    logic [3:0]        v_reg;
    front_t            out_reg;

    logic [PROD_W-FRAC_BITS-1:0] q1;
    logic [PROD_W+WORD_W-FRAC_BITS-1:0] full;

    always_comb begin
        fs = split(in_data.force_req);
        ts = split(in_data.torque);
        b_next.cmd  = in_data.cmd;
        b_next.last = in_data.last;
        b_next.act  = cfg.enable & in_data.grp;
        b_next.bad  = cfg.enable & in_data.grp &
                      ((in_data.mass == '0) | (in_data.radius == '0));
        b_next.nf   = fs[WORD_W];
        b_next.nt   = ts[WORD_W];
        b_next.mass = in_data.mass;
        b_next.vel  = in_data.vel;
        b_next.pos  = in_data.pos;
        b_next.spin = in_data.spin;
        q1   = rr1_reg[PROD_W-1:FRAC_BITS];
        full = (PROD_W+WORD_W-FRAC_BITS)'(plo2_reg) + {phi2_reg, {WORD_W{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
        if (ce) begin
            b0_reg   <= b_next;
            mf0_reg  <= fs[WORD_W-1:0];
            mt0_reg  <= ts[WORD_W-1:0];
            rad0_reg <= in_data.radius;

            b1_reg  <= b0_reg;
            pf1_reg <= cfg.half_step_force * mf0_reg;
            pt1_reg <= cfg.half_step_force * mt0_reg;
            rr1_reg <= rad0_reg * rad0_reg;

            // split the 48x32 product into two partial products
            b2_reg   <= b1_reg;
            pf2_reg  <= pf1_reg;
            pt2_reg  <= pt1_reg;
            plo2_reg <= q1[WORD_W-1:0] * b1_reg.mass;
            phi2_reg <= (PROD_W-FRAC_BITS)'(q1[PROD_W-FRAC_BITS-1:WORD_W] * b1_reg.mass);

            out_reg.b  <= b2_reg;
            out_reg.pf <= pf2_reg;
            out_reg.pt <= pt2_reg;
            out_reg.q2 <= full[PROD_W+WORD_W-FRAC_BITS-1:WORD_W-FRAC_BITS];
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = out_reg;

endmodule

[rtl/core/svvs_ph1.sv]
// Velocity increment dt_f*|f|/m by restoring division, one quotient bit per stage,
// with the inertia 2*q2/5 formed by shift-and-add in the first stages. Depends on svvs_pkg.
`timescale 1ns / 1ps
module svvs_ph1 (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ce,
    input  logic             in_valid,
    input  svvs_pkg::front_t in_data,
    output logic             out_valid,
    output svvs_pkg::ph1_t   out_data
);
    import svvs_pkg::*;

    function automatic ph1_t ph1_step(input ph1_t s, input int k);
        logic [WORD_W:0]   tv;
        logic              qv;
        logic [PROD_W+2:0] rem5;
        ph1_t              r;
        r    = s;
        rem5 = '0;
        tv = {s.vd_rem, s.vd_dvd[PROD_W]};
        qv = (tv >= {1'b0, s.b.mass});
        r.vd_rem = qv ? WORD_W'(tv - {1'b0, s.b.mass}) : tv[WORD_W-1:0];
        r.vd_q   = {s.vd_q[PROD_W-2:0], qv};
        r.vd_dvd = {s.vd_dvd[PROD_W-1:0], 1'b0};
        // scale by 0.8 with shifts and adds, quarter it, then fix up from the remainder
        unique case (k)
            0: r.i_est = (s.i_n >> 1) + (s.i_n >> 2);
            1: r.i_est = s.i_est + (s.i_est >> 4);
            2: r.i_est = s.i_est + (s.i_est >> 8);
            3: r.i_est = s.i_est + (s.i_est >> 16);
            4: r.i_est = s.i_est + (s.i_est >> 32);
            5: r.i_q   = s.i_est[PROD_W:2];
            6: begin
                rem5    = (PROD_W+3)'(s.i_n) - ((PROD_W+3)'(s.i_q) << 2)
                        - (PROD_W+3)'(s.i_q);
                r.i_est = rem5[PROD_W:0];
            end
            7: r.i_q = s.i_q + PROD_W'(s.i_est >= (PROD_W+1)'(FIVE))
                             + PROD_W'(s.i_est >= (PROD_W+1)'(2 * FIVE))
                             + PROD_W'(s.i_est >= (PROD_W+1)'(3 * FIVE));
            default: ;
        endcase
        return r;
    endfunction

    ph1_t              st  [PH1_STEPS+1];
    logic [PH1_STEPS:0] vld;

    assign st[0] = '{b: in_data.b, pt: in_data.pt, vd_dvd: {1'b0, in_data.pf},
                     vd_rem: '0, vd_q: '0, i_n: {in_data.q2, 1'b0}, i_est: '0,
                     i_q: '0};
    assign vld[0] = in_valid;

    for (genvar k = 0; k < PH1_STEPS; k++) begin : g_step
        ph1_t stage_reg;
        logic vld_reg;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (ce) begin
                vld_reg <= vld[k];
            end
            if (ce) begin
                stage_reg <= ph1_step(st[k], k);
            end
        end
        assign st[k+1]  = stage_reg;
        assign vld[k+1] = vld_reg;
    end

    assign out_valid = vld[PH1_STEPS];
    assign out_data  = st[PH1_STEPS];

endmodule

[rtl/core/svvs_ph2.sv]
// Back end: velocity and position update, spin increment division, final saturation.
// Depends on svvs_pkg.
`timescale 1ns / 1ps
module svvs_ph2 (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  svvs_pkg::cfg_t  cfg,
    input  logic            in_valid,
    input  svvs_pkg::ph1_t  in_data,
    output logic            out_valid,
    output svvs_pkg::out_t  out_data
);
    import svvs_pkg::*;

    typedef struct packed {
        base_t             b;
        logic [WORD_W-1:0] nv;
        logic [WORD_W-1:0] nx;
        logic              sat;
        logic [PROD_W-1:0] inertia;
        logic [PROD_W-1:0] t_dvd;
        logic [PROD_W-1:0] t_rem;
        logic [PROD_W-1:0] t_q;
    } ph2_t;

    function automatic ph2_t t_step(input ph2_t s);
        logic [PROD_W:0] tt;
        logic            q;
        ph2_t            r;
        r  = s;
        tt = {s.t_rem, s.t_dvd[PROD_W-1]};
        q  = (tt >= {1'b0, s.inertia});
        r.t_rem = q ? PROD_W'(tt - {1'b0, s.inertia}) : tt[PROD_W-1:0];
        r.t_q   = {s.t_q[PROD_W-2:0], q};
        r.t_dvd = {s.t_dvd[PROD_W-2:0], 1'b0};
        return r;
    endfunction

    logic [WORD_W:0] v_sum, vn_split, x_sum, w_sum;
    logic            huge;
    logic [PROD_W-1:0] dw;

    ph2_t              a_reg, b_reg;
    logic [WORD_W-1:0] mvn_a_reg;
    logic              nvn_a_reg, nvn_b_reg;
    logic [PROD_W-1:0] dx_b_reg;
    ph2_t              c_st;
    logic [2:0]        v_reg;
    ph2_t              c_reg;

    ph2_t              st  [PH2_STEPS+1];
    logic [PH2_STEPS:0] vld;

    out_t out_reg;
    logic out_v_reg;

    always_comb begin
        v_sum    = sat_add(in_data.b.vel, in_data.b.nf, in_data.vd_q, 1'b0);
        vn_split = split(v_sum[WORD_W-1:0]);
        x_sum    = sat_add(b_reg.b.pos, nvn_b_reg,
                           {{FRAC_BITS{1'b0}}, dx_b_reg[PROD_W-1:FRAC_BITS]}, 1'b0);
        c_st     = b_reg;
        if (!b_reg.b.cmd) begin
            c_st.nx  = x_sum[WORD_W-1:0];
            c_st.sat = b_reg.sat | x_sum[WORD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
        if (ce) begin
            a_reg.b       <= in_data.b;
            a_reg.nv      <= v_sum[WORD_W-1:0];
            a_reg.nx      <= in_data.b.pos;
            a_reg.sat     <= v_sum[WORD_W];
            a_reg.inertia <= in_data.i_q;
            a_reg.t_dvd   <= in_data.pt;
            a_reg.t_rem   <= '0;
            a_reg.t_q     <= '0;
            nvn_a_reg     <= vn_split[WORD_W];
            mvn_a_reg     <= vn_split[WORD_W-1:0];

            b_reg     <= a_reg;
            nvn_b_reg <= nvn_a_reg;
            dx_b_reg  <= cfg.step_time * mvn_a_reg;

            c_reg <= c_st;
        end
    end

    assign st[0]  = c_reg;
    assign vld[0] = v_reg[2];

    for (genvar k = 0; k < PH2_STEPS; k++) begin : g_step
        ph2_t stage_reg;
        logic vld_reg;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (ce) begin
                vld_reg <= vld[k];
            end
            if (ce) begin
                stage_reg <= t_step(st[k]);
            end
        end
        assign st[k+1]  = stage_reg;
        assign vld[k+1] = vld_reg;
    end

    // zero inertia: the remainder holds the whole numerator; nonzero drives spin to its limit
    always_comb begin
        if (st[PH2_STEPS].inertia == '0) begin
            huge = st[PH2_STEPS].t_rem != '0;
            dw   = '0;
        end else begin
            huge = 1'b0;
            dw   = st[PH2_STEPS].t_q;
        end
        w_sum = sat_add(st[PH2_STEPS].b.spin, st[PH2_STEPS].b.nt, dw, huge);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (ce) begin
            out_v_reg <= vld[PH2_STEPS];
        end
        if (ce) begin
            out_reg.last <= st[PH2_STEPS].b.last;
            if (!st[PH2_STEPS].b.act || st[PH2_STEPS].b.bad) begin
                out_reg.nv  <= st[PH2_STEPS].b.vel;
                out_reg.nx  <= st[PH2_STEPS].b.pos;
                out_reg.nw  <= st[PH2_STEPS].b.spin;
                out_reg.bad <= st[PH2_STEPS].b.bad;
                out_reg.sat <= 1'b0;
            end else begin
                out_reg.nv  <= st[PH2_STEPS].nv;
                out_reg.nx  <= st[PH2_STEPS].nx;
                out_reg.nw  <= w_sum[WORD_W-1:0];
                out_reg.bad <= 1'b0;
                out_reg.sat <= st[PH2_STEPS].sat | w_sum[WORD_W];
            end
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

[rtl/core/sphere_velocity_verlet_step.sv]
// Top level of the rigid-sphere velocity-Verlet step pipeline.
// Depends on svvs_pkg, svvs_front, svvs_ph1 and svvs_ph2.
//
// Usage:
//   s_ channel: one request per particle axis. s_tdata holds mass, radius,
//   force, torque, velocity, position and spin; s_tuser holds the command and
//   the group flag; s_tlast marks the last axis of a sweep.
//   m_ channel: one result per request, same order, with updated velocity,
//   position and spin in m_tdata and the bad-particle and clip flags in m_tuser.
//   cfg_ port: write enable, register index and data; takes effect at once.
// Throughput: one request per cycle, sustained while the output is not stalled.
// Pipeline: 4 entry stages, 65 stages of the velocity divider (one quotient
//   bit each, the inertia scaling runs alongside), 3 update stages, 64 stages
//   of the spin divider and the output register.
// Reset: all pipeline valid bits clear; enable = 1, step_time = 1.0,
//   half_step_force = 0.5.
// Stall: while m_tvalid is high and m_tready low, the whole pipeline holds
//   and s_tready is low; nothing is dropped or repeated.
`timescale 1ns / 1ps
module sphere_velocity_verlet_step (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mass, radius, force_req, torque, velocity, position, spin (32 bits each)
    input  logic [223:0] s_tdata,
    // command, in_group
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_velocity, new_position, new_spin (32 bits each)
    output logic [95:0]  m_tdata,
    // bad_particle, saturated
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);
    import svvs_pkg::*;

    cfg_t   cfg_reg;
    logic   ce;
    in_t    in_data;
    logic   f_valid, p1_valid, p2_valid;
    front_t f_data;
    ph1_t   p1_data;
    out_t   p2_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable          <= 1'b1;
            cfg_reg.step_time       <= 32'h0001_0000;
            cfg_reg.half_step_force <= 32'h0000_8000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ENABLE:          cfg_reg.enable          <= cfg_wdata[0];
                REG_STEP_TIME:       cfg_reg.step_time       <= cfg_wdata;
                REG_HALF_STEP_FORCE: cfg_reg.half_step_force <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance everything unless the output is held
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    always_comb begin
        in_data.cmd       = s_tuser[0];
        in_data.grp       = s_tuser[1];
        in_data.last      = s_tlast;
        in_data.mass      = s_tdata[31:0];
        in_data.radius    = s_tdata[63:32];
        in_data.force_req = s_tdata[95:64];
        in_data.torque    = s_tdata[127:96];
        in_data.vel       = s_tdata[159:128];
        in_data.pos       = s_tdata[191:160];
        in_data.spin      = s_tdata[223:192];
    end

    svvs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_data   (in_data),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    svvs_ph1 u_ph1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (p1_valid),
        .out_data  (p1_data)
    );

    svvs_ph2 u_ph2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .cfg       (cfg_reg),
        .in_valid  (p1_valid),
        .in_data   (p1_data),
        .out_valid (p2_valid),
        .out_data  (p2_data)
    );

    assign m_tvalid = p2_valid;
    assign m_tdata  = {p2_data.nw, p2_data.nx, p2_data.nv};
    assign m_tuser  = {p2_data.sat, p2_data.bad};
    assign m_tlast  = p2_data.last;

endmodule

[rtl/core/svvs_checker.sv]
// Port-level checks for sphere_velocity_verlet_step, attached by bind.
// Depends only on the top-level port list.
`timescale 1ns / 1ps
module svvs_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("held result changed");

    // the input side stalls exactly when a result is held
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // a result flagged as a bad particle never also reports clipping
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("bad_particle and saturated both set");

    // after a held result, the input is not ready unless the output has become ready
    a_nodrop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> !s_tready || m_tready)
        else $error("input accepted while result held");

endmodule

bind sphere_velocity_verlet_step svvs_checker u_svvs_checker (.*);

[dv/tb_sphere_velocity_verlet_step.sv]
// Self-checking bench for sphere_velocity_verlet_step: directed table, then random requests.
// Each result is compared with a local integer model of the step. Depends on svvs_pkg and the RTL.
`timescale 1ns / 1ps
module tb_sphere_velocity_verlet_step;
    import svvs_pkg::*;

    localparam logic CMD_FIRST = 1'b0;
    localparam logic CMD_FINAL = 1'b1;
    localparam int LATENCY     = 137;
    localparam int N_RANDOM    = 1750;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        cmd;
        logic        grp;
        logic        last;
        logic [31:0] mass;
        logic [31:0] radius;
        logic [31:0] force_req;
        logic [31:0] torque;
        logic [31:0] vel;
        logic [31:0] pos;
        logic [31:0] spin;
    } particle_t;

    typedef struct packed {
        logic [31:0] nv;
        logic [31:0] nx;
        logic [31:0] nw;
        logic        bad;
        logic        sat;
        logic        last;
    } motion_t;

    typedef struct {
        particle_t p;
        logic      known;
        motion_t   r;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = REG_ENABLE;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    sphere_velocity_verlet_step dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic        en_mdl;
    logic [31:0] dt_mdl;
    logic [31:0] dtf_mdl;
    motion_t     pending_motion[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          quiet = 1'b0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_sphere_velocity_verlet_step: errors");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // saturating add of a signed word and a signed 64-bit magnitude
    function automatic logic [31:0] clip_add(input logic [31:0] a, input logic nb,
                                             input logic [63:0] mb, input logic huge,
                                             inout logic sat);
        logic signed [65:0] sum;
        if (huge) begin
            sat = 1'b1;
            return nb ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        sum = 66'($signed(a)) + (nb ? -$signed({2'b00, mb}) : $signed({2'b00, mb}));
        if (sum > 66'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (sum < -66'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return sum[31:0];
    endfunction

    function automatic logic [31:0] magn(input logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    function automatic motion_t verlet_step(input particle_t p);
        motion_t     r;
        logic [63:0] d, q1, q2, inertia, mv;
        logic [127:0] w;
        logic        huge, sat;
        sat = 1'b0;
        r = '{nv: p.vel, nx: p.pos, nw: p.spin, bad: 1'b0, sat: 1'b0, last: p.last};
        if (en_mdl && p.grp) begin
            if (p.mass == 0 || p.radius == 0) begin
                r.bad = 1'b1;
            end else begin
                w = (128'(dtf_mdl) * magn(p.force_req)) / p.mass;
                huge = w[127:64] != 0;
                r.nv = clip_add(p.vel, p.force_req[31], w[63:0], huge, sat);
                if (p.cmd == CMD_FIRST) begin
                    mv = magn(r.nv);
                    w = (128'(dt_mdl) * mv) >> FRAC_BITS;
                    huge = w[127:64] != 0;
                    r.nx = clip_add(p.pos, r.nv[31], w[63:0], huge, sat);
                end
                q1 = (64'(p.radius) * p.radius) >> FRAC_BITS;
                w = (128'(q1) * p.mass) >> FRAC_BITS;
                q2 = (w[127:64] != 0) ? '1 : w[63:0];
                inertia = (q2 / 5) * 2 + ((q2 % 5) * 2) / 5;
                w = 128'(dtf_mdl) * magn(p.torque);
                if (inertia == 0) begin
                    huge = w != 0;
                    d = 0;
                end else begin
                    w = w / inertia;
                    huge = w[127:64] != 0;
                    d = w[63:0];
                end
                r.nw = clip_add(p.spin, p.torque[31], d, huge, sat);
                r.sat = sat;
            end
        end
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ENABLE:    en_mdl = val[0];
            REG_STEP_TIME: dt_mdl = val;
            default:       dtf_mdl = val;
        endcase
    endtask

    task automatic drain;
        while (pending_motion.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // hold s_tvalid across back-to-back requests; lower it only in a gap
    task automatic send(input particle_t p);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.spin, p.pos, p.vel, p.torque, p.force_req, p.radius, p.mass};
        s_tuser  <= {p.grp, p.cmd};
        s_tlast  <= p.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_motion.push_back(verlet_step(p));
    endtask

    task automatic send_row(input row_t row);
        send(row.p);
        if (row.known && pending_motion[$] != row.r) begin
            report("directed row vs table", pending_motion[$].nv, row.r.nv);
        end
    endtask

    task automatic idle_sender;
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // result checker and receiver stalls
    initial begin : sink
        int hold;
        motion_t want;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pending_motion.size() == 0) begin
                    report("unexpected result", m_tdata[31:0], '0);
                end else begin
                    want = pending_motion.pop_front();
                    if (m_tdata[31:0] !== want.nv)  report("new_velocity", m_tdata[31:0], want.nv);
                    if (m_tdata[63:32] !== want.nx) report("new_position", m_tdata[63:32], want.nx);
                    if (m_tdata[95:64] !== want.nw) report("new_spin", m_tdata[95:64], want.nw);
                    if (m_tuser[0] !== want.bad)
                        report("bad_particle", 32'(m_tuser[0]), 32'(want.bad));
                    if (m_tuser[1] !== want.sat)
                        report("saturated", 32'(m_tuser[1]), 32'(want.sat));
                    if (m_tlast !== want.last)
                        report("last_result", 32'(m_tlast), 32'(want.last));
                end
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
            3: return $urandom_range(0, 31) << $urandom_range(10, 22);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rnd_pos_word();
        case ($urandom_range(0, 5))
            0: return 32'hffff_ffff;
            1: return $urandom_range(1, 255);
            2: return $urandom_range(1, 8) << 16;
            3: return $urandom_range(1, 65535) << $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic particle_t rnd_particle();
        particle_t p;
        p.cmd       = 1'($urandom_range(0, 1));
        p.grp       = $urandom_range(0, 9) != 0;
        p.last      = $urandom_range(0, 7) == 0;
        p.mass      = ($urandom_range(0, 40) == 0) ? 32'h0 : rnd_pos_word();
        p.radius    = ($urandom_range(0, 40) == 0) ? 32'h0 : rnd_pos_word();
        p.force_req = rnd_word();
        p.torque    = rnd_word();
        p.vel       = rnd_word();
        p.pos       = rnd_word();
        p.spin      = rnd_word();
        return p;
    endfunction

    row_t table_rows[$];

    function automatic row_t mk(input logic cmd, input logic grp, input logic last,
                                input logic [31:0] m, input logic [31:0] r,
                                input logic [31:0] f, input logic [31:0] t,
                                input logic [31:0] v, input logic [31:0] x,
                                input logic [31:0] w, input logic known,
                                input motion_t res);
        row_t row;
        row.p = '{cmd, grp, last, m, r, f, t, v, x, w};
        row.known = known;
        row.r = res;
        return row;
    endfunction

    initial begin : stim
        logic [31:0] dts[4], dtfs[4];
        en_mdl = 1'b1;
        dt_mdl = 32'd65536;
        dtf_mdl = 32'd32768;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // out of group, zero mass, zero radius, inertia zero, extremes
        table_rows.push_back(mk(CMD_FIRST, 0, 0, 32'h1_0000, 32'h1_0000, 32'h7fff_ffff,
            32'h1234, 32'h5, 32'h6, 32'h7, 1, '{32'h5, 32'h6, 32'h7, 0, 0, 0}));
        table_rows.push_back(mk(CMD_FIRST, 1, 1, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1,
            32'h11, 32'h22, 32'h33, 1, '{32'h11, 32'h22, 32'h33, 1, 0, 1}));
        table_rows.push_back(mk(CMD_FINAL, 1, 0, 32'h1_0000, 32'h0, 32'h1_0000, 32'h1,
            32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1,
            '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1, 0, 0}));
        // unit mass and radius, force 1.0 at dt_f 0.5: v gains 0.5, x gains 0.5
        table_rows.push_back(mk(CMD_FIRST, 1, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h0,
            32'h0, 32'h0, 32'h0, 1, '{32'h8000, 32'h8000, 32'h0, 0, 0, 0}));
        table_rows.push_back(mk(CMD_FINAL, 1, 0, 32'h1_0000, 32'h1_0000, 32'hffff_0000, 32'h0,
            32'h0, 32'h1234, 32'h0, 1, '{32'hffff_8000, 32'h1234, 32'h0, 0, 0, 0}));
        table_rows.push_back(mk(CMD_FIRST, 1, 0, 32'h1, 32'h1, 32'h0, 32'h7fff_ffff,
            32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h7fff_ffff, 0, 1, 0}));
        table_rows.push_back(mk(CMD_FIRST, 1, 0, 32'h1, 32'h1, 32'h8000_0000, 32'h8000_0000,
            32'h0, 32'h0, 32'h0, 1, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1, 0}));
        table_rows.push_back(mk(CMD_FIRST, 1, 0, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, '0));
        table_rows.push_back(mk(CMD_FINAL, 1, 1, 32'hffff_ffff, 32'h1, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0));
        table_rows.push_back(mk(CMD_FIRST, 1, 0, 32'h3_0000, 32'h0_8000, 32'h2_0000,
            32'hfffe_0000, 32'h7fff_0000, 32'h8001_0000, 32'h10, 0, '0));
        table_rows.push_back(mk(CMD_FINAL, 1, 0, 32'h2_0000, 32'h2_0000, 32'hffff_ffff,
            32'h1, 32'hffff_ffff, 32'h0, 32'h1, 0, '0));
        foreach (table_rows[i]) send_row(table_rows[i]);
        idle_sender();
        drain();

        // disabled: everything passes through
        write_reg(REG_ENABLE, 32'h0);
        for (int i = 0; i < 12; i++) send(rnd_particle());
        idle_sender();
        drain();
        write_reg(REG_ENABLE, 32'h1);

        dts  = '{32'h0, 32'hffff_ffff, 32'h1_0000, 32'h0_0100};
        dtfs = '{32'hffff_ffff, 32'h0, 32'h0_8000, 32'h10_0000};
        for (int ph = 0; ph < 5; ph++) begin
            if (ph < 4) begin
                write_reg(REG_STEP_TIME, dts[ph]);
                write_reg(REG_HALF_STEP_FORCE, dtfs[ph]);
            end else begin
                write_reg(REG_STEP_TIME, $urandom);
                write_reg(REG_HALF_STEP_FORCE, $urandom_range(1, 32'h4_0000));
                quiet = 1'b1;
            end
            for (int i = 0; i < N_RANDOM / 5; i++) begin
                send(rnd_particle());
                if (ph == 2 && i == 100) begin
                    // hold off until every pending result is back
                    idle_sender();
                    while (pending_motion.size() != 0) @(posedge aclk);
                end
            end
            idle_sender();
            drain();
        end

        if (errors == 0) begin
            $display("tb_sphere_velocity_verlet_step: clean");
        end else begin
            $display("tb_sphere_velocity_verlet_step: errors");
        end
        $finish;
    end
endmodule
